// ===== sv/chunked_body_decoder_unit_macros.svh =====
// Assertion macros used by the chunked body decoder core.
`ifndef CHUNKED_BODY_DECODER_UNIT_MACROS_SVH
`define CHUNKED_BODY_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/chbd_pkg.sv =====
// Shared types, constants and helper functions of the chunked body decoder.
package chbd_pkg;

   // Width of a chunk size and of the body byte counter.
   localparam int SIZE_BITS = 32;
   localparam int CNT_BITS  = SIZE_BITS + 1;

   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [CNT_BITS-1:0]  count_type;

   localparam size_type SIZE_MAX = {SIZE_BITS{1'b1}};

   // Input opcodes.
   localparam logic [1:0] OP_DATA  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_CLOSE = 2'd2;

   // Result kinds.
   localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_CLOSED   = 2'd2;

   // Characters the size line parser looks for.
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_VT    = 8'h0B;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SP    = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_UX    = 8'h58;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF_HEX = 8'h66;
   localparam logic [7:0] CHAR_LX    = 8'h78;

   // One input beat.
   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] in_byte;
   } item_type;

   // One result beat, with its valid flag.
   typedef struct packed {
      logic       valid;
      logic [7:0] out_byte;
      logic [1:0] out_kind;
   } result_type;

   // Hex digit decode: bit 4 is set for a hex digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
         r = {1'b1, 4'(b - CHAR_ZERO)};
      end else if (b >= CHAR_LA && b <= CHAR_LF_HEX) begin
         r = {1'b1, 4'(b - CHAR_LA + 8'd10)};
      end else if (b >= CHAR_UA && b <= CHAR_UF) begin
         r = {1'b1, 4'(b - CHAR_UA + 8'd10)};
      end
      return r;
   endfunction

   // Shift one hex digit into a size, saturating at the maximum.
   function automatic size_type add_digit(input size_type v, input logic [3:0] d);
      size_type r;
      if (v > (SIZE_MAX >> 4)) begin
         r = SIZE_MAX;
      end else begin
         r = {v[SIZE_BITS-5:0], d};
      end
      return r;
   endfunction

endpackage

// ===== sv/chunked_body_decoder_unit.sv =====
// Top level of the chunked body decoder: input register, parser core, output register.
//
//   Channel | Direction | Beat contents
//   req_    | in        | tdata[7:0] = in_byte; tuser[1:0] = opcode
//   rsp_    | out       | tdata[7:0] = out_byte; tuser[1:0] = out_kind
//
// One beat is accepted per cycle while no result waits on a full output register; its result
// is held in the output register for rsp_. The rate is set by the combinational parser step between the registers.
// A beat that yields a result waits in the input register while the output register is full.
// Reset is synchronous and returns the parser to the start of a size line.
module chunked_body_decoder_unit
   import chbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic [1:0] req_tuser,   // [1:0] opcode
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser    // [1:0] out_kind
);

   item_type   in_item;
   item_type   item;
   logic       item_valid;
   result_type res;
   logic       out_free;
   logic       fire;

   assign in_item.opcode  = req_tuser;
   assign in_item.in_byte = req_tdata;

   // A held beat moves on unless its result has nowhere to go.
   assign fire = item_valid && (!res.valid || out_free);

   chbd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .fire       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   chbd_core u_core (
      .clock (clock),
      .reset (reset),
      .item  (item),
      .fire  (fire),
      .res   (res)
   );

   chbd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res       (res),
      .load      (fire),
      .out_free  (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_kind  (rsp_tuser)
   );

endmodule

// ===== sv/chbd_in_stage.sv =====
// Input register stage that holds one accepted beat for the decoder core.
module chbd_in_stage
   import chbd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   input  logic     fire,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   // Room for a new beat when empty or when the held beat moves on now.
   assign in_ready = !valid_ff || fire;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/chbd_core.sv =====
// Decoder state and the per-beat step of the chunked body parser.
`include "chunked_body_decoder_unit_macros.svh"

module chbd_core
   import chbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       fire,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_LEAD, PH_SIGN, PH_ZERO, PH_PFX, PH_DIGITS, PH_SKIP, PH_BODY, PH_DONE
   } phase_type;

   phase_type phase_ff, phase_in;
   count_type count_ff, count_in;
   logic      cr_ff, cr_in;
   logic      neg_ff, neg_in;
   logic      seen_ff, seen_in;

   logic [4:0] hex;
   size_type   size_add;
   count_type  count_dec;

   assign hex       = hex_value(item.in_byte);
   assign size_add  = add_digit(count_ff[SIZE_BITS-1:0], hex[3:0]);
   assign count_dec = count_ff - CNT_BITS'(count_ff != '0);

   // Next state and result for the beat held in the input register.
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      cr_in    = cr_ff;
      neg_in   = neg_ff;
      seen_in  = seen_ff;
      res      = '0;
      case (item.opcode)
         OP_START: begin
            phase_in = PH_LEAD;
            count_in = '0;
            cr_in    = 1'b0;
            neg_in   = 1'b0;
            seen_in  = 1'b0;
         end
         OP_CLOSE: begin
            if (phase_ff != PH_DONE) begin
               phase_in     = PH_DONE;
               res.valid    = 1'b1;
               res.out_kind = KIND_CLOSED;
            end
         end
         OP_DATA: begin
            if (phase_ff == PH_DONE) begin
               // Trailer and late bytes are dropped.
            end else if (phase_ff == PH_BODY) begin
               // The last two counted bytes are the chunk's line end.
               if (count_ff > CNT_BITS'(2)) begin
                  res.valid    = 1'b1;
                  res.out_byte = item.in_byte;
                  res.out_kind = KIND_PAYLOAD;
               end
               count_in = count_dec;
               if (count_dec == '0) begin
                  phase_in = PH_LEAD;
                  cr_in    = 1'b0;
                  neg_in   = 1'b0;
                  seen_in  = 1'b0;
               end
            end else if (cr_ff && item.in_byte == CHAR_LF) begin
               // End of a size line: either the body ends or a chunk starts.
               cr_in = 1'b0;
               if (!seen_ff || neg_ff || count_ff == '0) begin
                  phase_in     = PH_DONE;
                  res.valid    = 1'b1;
                  res.out_kind = KIND_COMPLETE;
               end else begin
                  count_in = count_ff + CNT_BITS'(2);
                  phase_in = PH_BODY;
               end
            end else begin
               cr_in = (item.in_byte == CHAR_CR);
               unique case (phase_ff)
                  PH_LEAD, PH_SIGN: begin
                     if (phase_ff == PH_LEAD && item.in_byte inside
                         {CHAR_SP, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR}) begin
                        // Leading white space is skipped.
                     end else if (phase_ff == PH_LEAD && (item.in_byte == CHAR_PLUS ||
                                  item.in_byte == CHAR_MINUS)) begin
                        neg_in   = (item.in_byte == CHAR_MINUS);
                        phase_in = PH_SIGN;
                     end else if (hex[4]) begin
                        count_in = CNT_BITS'(size_add);
                        seen_in  = 1'b1;
                        phase_in = (item.in_byte == CHAR_ZERO) ? PH_ZERO : PH_DIGITS;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_ZERO: begin
                     if (item.in_byte == CHAR_LX || item.in_byte == CHAR_UX) begin
                        phase_in = PH_PFX;
                     end else if (hex[4]) begin
                        count_in = CNT_BITS'(size_add);
                        seen_in  = 1'b1;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_PFX, PH_DIGITS: begin
                     if (hex[4]) begin
                        count_in = CNT_BITS'(size_add);
                        seen_in  = 1'b1;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_SKIP;
                     end
                  end
                  default: begin
                     // The rest of the line is ignored.
                  end
               endcase
            end
         end
         default: begin
            // Unknown opcode leaves everything as it is.
         end
      endcase
   end

   // State commits only when the held beat moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         count_ff <= '0;
         cr_ff    <= 1'b0;
         neg_ff   <= 1'b0;
         seen_ff  <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         cr_ff    <= cr_in;
         neg_ff   <= neg_in;
         seen_ff  <= seen_in;
      end
   end

   `CBD_ASSERT_NEXT(a_start_clears, clock, reset, fire && item.opcode == OP_START,
      phase_ff == PH_LEAD && count_ff == '0 && !seen_ff, "start beat did not clear state")
   `CBD_ASSERT_SAME(a_done_silent, clock, reset,
      phase_ff == PH_DONE && item.opcode == OP_DATA, !res.valid, "result after body end")
   `CBD_ASSERT_SAME(a_payload_in_body, clock, reset,
      res.valid && res.out_kind == KIND_PAYLOAD, phase_ff == PH_BODY,
      "payload byte outside a chunk")
   `CBD_ASSERT_SAME(a_size_bounded, clock, reset, phase_ff != PH_BODY && phase_ff != PH_DONE,
      count_ff <= CNT_BITS'(SIZE_MAX), "size line value above the saturation limit")

endmodule

// ===== sv/chbd_out_stage.sv =====
// Output register that holds one result beat until the consumer takes it.
module chbd_out_stage
   import chbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type res,
   input  logic       load,
   output logic       out_free,
   output logic       out_valid,
   input  logic       out_ready,
   output logic [7:0] out_byte,
   output logic [1:0] out_kind
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic [1:0] kind_ff;

   // The slot is free when empty or drained in this cycle.
   assign out_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load && res.valid) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && res.valid) begin
         byte_ff <= res.out_byte;
         kind_ff <= res.out_kind;
      end
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_kind  = kind_ff;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the chunked body decoder: directed and random chunked bodies.
`timescale 1ns / 100ps

module testbench;
   import chbd_pkg::*;

   localparam int ITEM_GOAL    = 1250;
   localparam int IDLE_PCT     = 37;
   localparam int HOLD_AFTER   = 300;
   localparam int HOLD_CYCLES  = 120;
   localparam int QUIET_FROM   = 600;
   localparam int QUIET_BEATS  = 250;
   localparam int DRAIN_CYCLES = 16;
   localparam int PRINT_CAP    = 40;
   localparam longint LIMIT_NS = 3_000_000;

   // Characters the generator needs beyond those in the package.
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   // Opcode that the decoder ignores.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Size line parser phases of the local decoder.
   typedef enum logic [2:0] {
      PH_LEAD, PH_SIGN, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_SKIP, PH_BODY, PH_DONE
   } line_phase_type;

   // How a beat's result is judged: by the local decoder, by a value typed in, or not at all.
   typedef enum logic [1:0] { CHECK_MODEL, CHECK_NONE, CHECK_ONE } check_mode_type;

   typedef logic [SIZE_BITS+1:0] chunk_count_type;

   typedef struct packed {
      logic [1:0]     opcode;
      logic [7:0]     data;
      check_mode_type mode;
      logic [1:0]     kind;
      logic [7:0]     payload;
   } body_beat_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
   } decoded_type;

   // Directed beats: early close, negative size, lone prefix, late prefix,
   // extreme payload values and an unknown opcode inside a chunk.
   localparam int DIR_ROWS = 28;
   localparam body_beat_type DIRECTED [DIR_ROWS] = '{
      '{OP_CLOSE, 8'h00,      CHECK_ONE,   KIND_CLOSED,   8'h00},
      '{OP_CLOSE, 8'h00,      CHECK_NONE,  KIND_PAYLOAD,  8'h00},
      '{OP_START, 8'h00,      CHECK_NONE,  KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_MINUS, CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_UF,    CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_CR,    CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_LF,    CHECK_ONE,   KIND_COMPLETE, 8'h00},
      '{OP_START, 8'hFF,      CHECK_NONE,  KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_ZERO,  CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_LX,    CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_CR,    CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_LF,    CHECK_ONE,   KIND_COMPLETE, 8'h00},
      '{OP_START, 8'h00,      CHECK_NONE,  KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_ZERO,  CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_ZERO,  CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_UX,    CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_CR,    CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_LF,    CHECK_ONE,   KIND_COMPLETE, 8'h00},
      '{OP_START, 8'h00,      CHECK_NONE,  KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  8'h32,      CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_CR,    CHECK_MODEL, KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_LF,    CHECK_NONE,  KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  8'hFF,      CHECK_ONE,   KIND_PAYLOAD,  8'hFF},
      '{OP_UNUSED, 8'hAA,     CHECK_NONE,  KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  8'h00,      CHECK_ONE,   KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_CR,    CHECK_NONE,  KIND_PAYLOAD,  8'h00},
      '{OP_DATA,  CHAR_LF,    CHECK_NONE,  KIND_PAYLOAD,  8'h00},
      '{OP_CLOSE, 8'h00,      CHECK_ONE,   KIND_CLOSED,   8'h00}
   };

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic [1:0] req_tuser  = OP_DATA;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   body_beat_type stim_q[$];
   decoded_type   decoded_due_q[$];
   int            accept_idx     = 0;
   int            mismatch_count = 0;
   int            bodies_built   = 0;
   int            seen_payload   = 0;
   int            seen_complete  = 0;
   int            seen_closed    = 0;

   // State of the local decoder.
   line_phase_type  phase_now  = PH_LEAD;
   chunk_count_type chunk_left = '0;
   bit              cr_before  = 1'b0;
   bit              minus_seen = 1'b0;
   bit              digit_read = 1'b0;

   chunked_body_decoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The run is cut off here if the decoder hangs.
   initial begin
      #(LIMIT_NS);
      $display("== FAIL ==");
      $finish;
   end

   function automatic bit chance(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // Both sides idle at random, except over one quiet stretch of beats.
   function automatic bit takes_break();
      if (accept_idx >= DIR_ROWS + QUIET_FROM && accept_idx < DIR_ROWS + QUIET_FROM + QUIET_BEATS)
         return 1'b0;
      return chance(IDLE_PCT);
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_CAP) $display("%0t: mismatch, %s", $time, what);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Local decoder
   // ---------------------------------------------------------------------

   // Value of a hex digit, or -1 for any other byte.
   function automatic int digit_weight(input logic [7:0] b);
      if (b >= CHAR_ZERO && b <= CHAR_NINE) return int'(b - CHAR_ZERO);
      if (b >= CHAR_LA && b <= CHAR_LF_HEX) return int'(b - CHAR_LA) + 10;
      if (b >= CHAR_UA && b <= CHAR_UF) return int'(b - CHAR_UA) + 10;
      return -1;
   endfunction

   function automatic bit is_blank(input logic [7:0] b);
      return b == CHAR_SP || b == CHAR_TAB || b == CHAR_LF || b == CHAR_VT ||
             b == CHAR_FF || b == CHAR_CR;
   endfunction

   function automatic void clear_line();
      phase_now  = PH_LEAD;
      chunk_left = '0;
      cr_before  = 1'b0;
      minus_seen = 1'b0;
      digit_read = 1'b0;
   endfunction

   // Shift one hex digit into the chunk size, saturating at the largest size.
   function automatic void take_digit(input logic [3:0] d);
      digit_read = 1'b1;
      if (chunk_left > chunk_count_type'(SIZE_MAX >> 4)) chunk_left = chunk_count_type'(SIZE_MAX);
      else chunk_left = (chunk_left << 4) | chunk_count_type'(d);
   endfunction

   // First character of the number, after white space or a sign.
   function automatic void number_begins(input logic [7:0] b, input int w);
      if (b == CHAR_ZERO) begin
         take_digit(4'd0);
         phase_now = PH_ZERO;
      end else if (w >= 0) begin
         take_digit(4'(w));
         phase_now = PH_DIGITS;
      end else begin
         phase_now = PH_SKIP;
      end
   endfunction

   function automatic void parse_size_char(input logic [7:0] b);
      int w;
      w = digit_weight(b);
      case (phase_now)
         PH_LEAD: begin
            if (is_blank(b)) begin
               // White space before the number is skipped.
            end else if (b == CHAR_PLUS || b == CHAR_MINUS) begin
               minus_seen = (b == CHAR_MINUS);
               phase_now  = PH_SIGN;
            end else begin
               number_begins(b, w);
            end
         end
         PH_SIGN: number_begins(b, w);
         PH_ZERO: begin
            if (b == CHAR_LX || b == CHAR_UX) begin
               phase_now = PH_PREFIX;
            end else if (w >= 0) begin
               take_digit(4'(w));
               phase_now = PH_DIGITS;
            end else begin
               phase_now = PH_SKIP;
            end
         end
         PH_PREFIX, PH_DIGITS: begin
            if (w >= 0) begin
               take_digit(4'(w));
               phase_now = PH_DIGITS;
            end else begin
               phase_now = PH_SKIP;
            end
         end
         default: ;
      endcase
   endfunction

   // One accepted beat through the decoder; fresh is set when it yields a result.
   function automatic void decode_beat(input logic [1:0] opcode, input logic [7:0] b,
                                       output bit fresh, output decoded_type res);
      fresh = 1'b0;
      res   = '{8'h00, KIND_PAYLOAD};
      if (opcode == OP_START) begin
         clear_line();
      end else if (opcode == OP_CLOSE) begin
         if (phase_now != PH_DONE) begin
            phase_now = PH_DONE;
            fresh     = 1'b1;
            res       = '{8'h00, KIND_CLOSED};
         end
      end else if (opcode == OP_DATA && phase_now != PH_DONE) begin
         if (phase_now == PH_BODY) begin
            // The last two bytes of a chunk are dropped unchecked.
            if (chunk_left > 2) begin
               fresh = 1'b1;
               res   = '{b, KIND_PAYLOAD};
            end
            if (chunk_left != 0) chunk_left--;
            if (chunk_left == 0) clear_line();
         end else if (cr_before && b == CHAR_LF) begin
            cr_before = 1'b0;
            if (!digit_read || minus_seen || chunk_left == 0) begin
               phase_now = PH_DONE;
               fresh     = 1'b1;
               res       = '{8'h00, KIND_COMPLETE};
            end else begin
               chunk_left = chunk_left + 2;
               phase_now  = PH_BODY;
            end
         end else begin
            parse_size_char(b);
            cr_before = (b == CHAR_CR);
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------

   function automatic void add_beat(input logic [1:0] opcode, input logic [7:0] data);
      stim_q.push_back('{opcode, data, CHECK_MODEL, KIND_PAYLOAD, 8'h00});
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // Any byte except CR, for text that must not end the line.
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      b = any_byte();
      if (b == CHAR_CR) b = CHAR_SEMI;
      return b;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      if (d < 4'd10) return CHAR_ZERO + 8'(d);
      return (chance(50) ? CHAR_UA : CHAR_LA) + 8'(d) - 8'd10;
   endfunction

   function automatic void add_line_end();
      add_beat(OP_DATA, CHAR_CR);
      add_beat(OP_DATA, CHAR_LF);
   endfunction

   // A size line in one of the many spellings the parser accepts.
   function automatic void add_size_line(input int unsigned size);
      int n_dig;
      int k;
      n_dig = 1;
      while (n_dig < 8 && (size >> (4 * n_dig)) != 0) n_dig++;
      if (chance(30)) begin
         for (k = $urandom_range(1, 3); k > 0; k--) begin
            case ($urandom_range(0, 3))
               0: add_beat(OP_DATA, CHAR_SP);
               1: add_beat(OP_DATA, CHAR_TAB);
               2: add_beat(OP_DATA, CHAR_VT);
               default: add_beat(OP_DATA, CHAR_FF);
            endcase
         end
      end
      if (chance(10)) add_beat(OP_DATA, CHAR_PLUS);
      if (chance(20)) begin
         add_beat(OP_DATA, CHAR_ZERO);
         add_beat(OP_DATA, chance(50) ? CHAR_LX : CHAR_UX);
      end else if (chance(10)) begin
         add_beat(OP_DATA, CHAR_ZERO);
      end
      for (k = n_dig - 1; k >= 0; k--) add_beat(OP_DATA, hex_char(4'(size >> (4 * k))));
      // Extension or stray text, ignored up to the line end.
      if (chance(30)) begin
         add_beat(OP_DATA, chance(80) ? CHAR_SEMI : CHAR_SP);
         for (k = $urandom_range(0, 6); k > 0; k--) add_beat(OP_DATA, text_byte());
      end
      add_line_end();
   endfunction

   // A line that ends the body: zero, lone prefix, negative, no digits, late prefix, signed zero.
   function automatic void add_last_line();
      case ($urandom_range(0, 5))
         0: add_size_line(0);
         1: begin
            add_beat(OP_DATA, CHAR_ZERO);
            add_beat(OP_DATA, CHAR_LX);
            add_line_end();
         end
         2: begin
            add_beat(OP_DATA, CHAR_MINUS);
            add_beat(OP_DATA, hex_char(4'($urandom_range(1, 15))));
            add_line_end();
         end
         3: begin
            if (chance(50)) add_beat(OP_DATA, CHAR_SEMI);
            add_line_end();
         end
         4: begin
            add_beat(OP_DATA, CHAR_ZERO);
            add_beat(OP_DATA, CHAR_ZERO);
            add_beat(OP_DATA, CHAR_UX);
            add_beat(OP_DATA, hex_char(4'($urandom_range(1, 15))));
            add_line_end();
         end
         default: begin
            add_beat(OP_DATA, CHAR_PLUS);
            add_beat(OP_DATA, CHAR_ZERO);
            add_line_end();
         end
      endcase
   endfunction

   // A size too large for the counter; a few bytes of it, then a fresh start.
   function automatic void add_oversized_chunk();
      int k;
      add_beat(OP_DATA, chance(50) ? CHAR_UF : CHAR_LF_HEX);
      for (k = $urandom_range(8, 11); k > 0; k--)
         add_beat(OP_DATA, hex_char(4'($urandom_range(0, 15))));
      add_line_end();
      for (k = $urandom_range(1, 12); k > 0; k--) add_beat(OP_DATA, any_byte());
      add_beat(OP_START, any_byte());
   endfunction

   function automatic void add_body();
      int n_chunks;
      int size;
      int k;
      int j;
      bodies_built++;
      if (!chance(3)) add_beat(OP_START, any_byte());
      n_chunks = $urandom_range(0, 4);
      for (k = 0; k < n_chunks; k++) begin
         if (chance(4)) begin
            add_oversized_chunk();
            return;
         end
         size = chance(85) ? $urandom_range(1, 16) : $urandom_range(17, 96);
         add_size_line(size);
         for (j = 0; j < size; j++) begin
            if (chance(1)) begin
               add_beat(OP_CLOSE, any_byte());
               return;
            end
            add_beat(OP_DATA, any_byte());
         end
         if (chance(85)) begin
            add_line_end();
         end else begin
            add_beat(OP_DATA, any_byte());
            add_beat(OP_DATA, any_byte());
         end
      end
      add_last_line();
      // Trailer bytes and a close after the end are both ignored.
      if (chance(30)) begin
         for (k = $urandom_range(1, 8); k > 0; k--) add_beat(OP_DATA, any_byte());
      end
      if (chance(30)) add_beat(OP_CLOSE, any_byte());
   endfunction

   function automatic void add_noise();
      int k;
      for (k = $urandom_range(5, 25); k > 0; k--) add_beat(2'($urandom_range(0, 3)), any_byte());
   endfunction

   // ---------------------------------------------------------------------
   // Driving, receiving and checking
   // ---------------------------------------------------------------------

   task automatic send_beats();
      int k;
      k = 0;
      while (k < stim_q.size()) begin
         @(negedge clock);
         if (takes_break()) begin
            req_tvalid = 1'b0;
         end else begin
            req_tvalid = 1'b1;
            req_tuser  = stim_q[k].opcode;
            req_tdata  = stim_q[k].data;
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            k++;
         end
      end
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // The receiver stalls at random and holds off once for a long stretch.
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && accept_idx >= DIR_ROWS + HOLD_AFTER) begin
            held       = 1'b1;
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready = !takes_break();
      end
   end

   // Check each result beat, then predict from each accepted beat.
   always @(posedge clock) begin
      decoded_type   want;
      decoded_type   pred;
      bit            fresh;
      body_beat_type row;
      if (reset) begin
         clear_line();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_due_q.size() == 0) begin
               report_mismatch($sformatf("result kind %0d byte %02h with nothing expected",
                                         rsp_tuser, rsp_tdata));
            end else begin
               want = decoded_due_q.pop_front();
               if (rsp_tuser !== want.out_kind)
                  report_mismatch($sformatf("kind %0d, expected %0d", rsp_tuser, want.out_kind));
               if (rsp_tdata !== want.out_byte)
                  report_mismatch($sformatf("byte %02h, expected %02h", rsp_tdata, want.out_byte));
            end
            case (rsp_tuser)
               KIND_PAYLOAD:  seen_payload++;
               KIND_COMPLETE: seen_complete++;
               default:       seen_closed++;
            endcase
         end
         if (req_tvalid && req_tready) begin
            row = stim_q[accept_idx];
            decode_beat(req_tuser, req_tdata, fresh, pred);
            case (row.mode)
               CHECK_MODEL: if (fresh) decoded_due_q.push_back(pred);
               CHECK_ONE:   decoded_due_q.push_back('{row.payload, row.kind});
               default: ;
            endcase
            accept_idx++;
         end
      end
   end

   // Build the stimulus, run it, drain the results and judge the run.
   initial begin
      int k;
      for (k = 0; k < DIR_ROWS; k++) stim_q.push_back(DIRECTED[k]);
      while (stim_q.size() < DIR_ROWS + ITEM_GOAL) begin
         if (chance(7)) add_noise();
         else add_body();
      end
      repeat (10) @(negedge clock);
      reset = 1'b0;
      send_beats();
      while (decoded_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d beats: %0d directed, the rest from %0d random bodies and noise.",
               stim_q.size(), DIR_ROWS, bodies_built);
      $display("Checked %0d payload bytes, %0d completed bodies, %0d early closes.",
               seen_payload, seen_complete, seen_closed);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
